// ===== rtl/rcsg_pkg.sv =====
// Shared constants, widths and register codes of the random channel subset gate.
`timescale 1ns / 1ps
`default_nettype none
package rcsg_pkg;

  // Channel count and the widths that follow from it.
  localparam int CHANNELS = 8;
  localparam int MASK_W   = 8;
  localparam int USED_CH  = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
  localparam int SIDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(CHANNELS + 1);
  localparam int CH_ID_W  = 3;
  localparam int PROD_W   = CNT_W + 8;

  // Field widths.
  localparam int MV_W     = 15;
  localparam int PERM_W   = 10;
  localparam int RND_W    = 64;
  localparam int COUNT_W  = 4;
  localparam int PPROD_W  = CNT_W + PERM_W;

  // Packed stream widths.
  localparam int IN_BITS  = 2 * MV_W + 2 + MASK_W + RND_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = MASK_W + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Probability full scale in per mille.
  localparam logic [PERM_W-1:0] PERM_MAX = PERM_W'(1000);

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PROB_KNOB = 2'd0,
    REG_TRIG_HIGH = 2'd1,
    REG_TRIG_LOW  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_e;

  // Register reset values.
  localparam logic [PERM_W-1:0]      PROB_KNOB_RST = PERM_W'(500);
  localparam logic signed [MV_W-1:0] TRIG_HIGH_RST = MV_W'(1000);
  localparam logic signed [MV_W-1:0] TRIG_LOW_RST  = MV_W'(0);

endpackage
`default_nettype wire

// ===== rtl/random_channel_subset_gate_unit.sv =====
// Top level of the random channel subset gate: trigger detect, shuffle and enable selection.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel      | direction | handshake                     | payload
//  -------------+-----------+-------------------------------+------------------------------
//  sample in    | slave     | s_axis_tvalid / s_axis_tready | s_axis_tdata (104 bits)
//  result out   | master    | m_axis_tvalid / m_axis_tready | m_axis_tdata (16 bits)
//  config       | APB slave | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  One request is taken per cycle unless the stage register is held. Trigger detection
//  and the detector state update happen in the accept cycle; a firing request is held in
//  the stage register and the shuffle plus enable selection runs from it into the result
//  register, which takes the result as soon as it is free. A request that does not fire
//  leaves no result. The input keeps flowing while a result waits: the stage register
//  stalls only when the result register is full and not taken. Reset clears the detector
//  state, the valid flags and restores the register defaults.
//
module random_channel_subset_gate_unit
  import rcsg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // sample in
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata, low bit up: trig_mv[14:0], button[15], prob_mv[30:16], prob_connected[31],
  // connected_mask[39:32], random_bits[103:40]
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  // result out
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata, low bit up: enable_mask[7:0], enabled_count[11:8], zero fill[15:12]
  output logic [OUT_W-1:0]       m_axis_tdata,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  // Configuration registers.
  logic [PERM_W-1:0]      prob_knob_q;
  logic signed [MV_W-1:0] trig_high_q;
  logic signed [MV_W-1:0] trig_low_q;
  reg_idx_e               reg_idx;
  logic                   cfg_wr;

  // Detector state.
  logic schmitt_high_q, schmitt_high_d;
  logic button_last_q;

  // Input field views.
  logic signed [MV_W-1:0] in_trig;
  logic                   in_button;
  logic signed [MV_W-1:0] in_pmv;
  logic                   in_pcon;
  logic [MASK_W-1:0]      in_cmask;
  logic [RND_W-1:0]       in_rnd;

  logic              in_acc;
  logic              fire;
  logic              clk_fire;
  logic [PERM_W-1:0] p_sel;

  // Stage register.
  logic              s1_valid_q, s1_valid_d;
  logic [PERM_W-1:0] s1_p_q;
  logic [MASK_W-1:0] s1_cmask_q;
  logic [RND_W-1:0]  s1_rnd_q;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic [MASK_W-1:0]  out_mask_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic               s2_free;

  // Shuffle datapath.
  logic [CH_ID_W-1:0] slot [CHANNELS];
  logic [CNT_W-1:0]   n;
  logic [2:0]         k;
  logic [7:0]         b;
  logic [PROD_W-1:0]  prod;
  logic [SIDX_W-1:0]  s;
  logic [PPROD_W-1:0] pprod;
  logic [CNT_W-1:0]   en;
  logic [MASK_W-1:0]  mask;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_PROB_KNOB: prdata = DATA_W'(prob_knob_q);
      REG_TRIG_HIGH: prdata = DATA_W'(trig_high_q);
      REG_TRIG_LOW:  prdata = DATA_W'(trig_low_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prob_knob_q <= PROB_KNOB_RST;
      trig_high_q <= TRIG_HIGH_RST;
      trig_low_q  <= TRIG_LOW_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROB_KNOB: prob_knob_q <= pwdata[PERM_W-1:0];
        REG_TRIG_HIGH: trig_high_q <= pwdata[MV_W-1:0];
        REG_TRIG_LOW:  trig_low_q  <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input unpack and trigger detect ----------------
  assign in_trig   = s_axis_tdata[MV_W-1:0];
  assign in_button = s_axis_tdata[MV_W];
  assign in_pmv    = s_axis_tdata[2*MV_W:MV_W+1];
  assign in_pcon   = s_axis_tdata[2*MV_W+1];
  assign in_cmask  = s_axis_tdata[2*MV_W+2 +: MASK_W];
  assign in_rnd    = s_axis_tdata[2*MV_W+2+MASK_W +: RND_W];

  assign s2_free       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s2_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Schmitt trigger: drop at or below the low threshold, rise and fire at or above the high one.
  always_comb begin
    schmitt_high_d = schmitt_high_q;
    clk_fire       = 1'b0;
    if (schmitt_high_q) begin
      if (in_trig <= trig_low_q) schmitt_high_d = 1'b0;
    end else if (in_trig >= trig_high_q) begin
      schmitt_high_d = 1'b1;
      clk_fire       = 1'b1;
    end
  end

  assign fire = clk_fire || (in_button && !button_last_q);

  // Clamp the probability to 0..1000 per mille.
  always_comb begin
    if (in_pcon) begin
      if (in_pmv < 0) begin
        p_sel = '0;
      end else if (in_pmv > $signed({1'b0, {(MV_W-PERM_W-1){1'b0}}, PERM_MAX})) begin
        p_sel = PERM_MAX;
      end else begin
        p_sel = in_pmv[PERM_W-1:0];
      end
    end else begin
      p_sel = (prob_knob_q > PERM_MAX) ? PERM_MAX : prob_knob_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      schmitt_high_q <= 1'b0;
      button_last_q  <= 1'b0;
    end else if (in_acc) begin
      schmitt_high_q <= schmitt_high_d;
      button_last_q  <= in_button;
    end
  end

  // Hold a firing request in the stage register; drop the rest.
  always_comb begin
    if (in_acc) begin
      s1_valid_d = fire;
    end else if (s2_free) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_p_q     <= p_sel;
      s1_cmask_q <= in_cmask;
      s1_rnd_q   <= in_rnd;
    end
  end

  // ---------------- inside-out shuffle ----------------
  // Each connected channel after the first swaps into a slot picked by its random byte.
  always_comb begin
    for (int j = 0; j < CHANNELS; j++) slot[j] = '0;
    n    = '0;
    k    = '0;
    b    = '0;
    prod = '0;
    s    = '0;
    for (int i = 0; i < USED_CH; i++) begin
      if (s1_cmask_q[i]) begin
        n = n + CNT_W'(1);
        if (n == CNT_W'(1)) begin
          slot[0] = CH_ID_W'(i);
        end else begin
          k    = 3'(n - CNT_W'(2));
          b    = s1_rnd_q[{k, 3'b000} +: 8];
          prod = PROD_W'(n) * PROD_W'(b);
          s    = SIDX_W'(prod >> 8);
          slot[SIDX_W'(n - CNT_W'(1))] = slot[s];
          slot[s] = CH_ID_W'(i);
        end
      end
    end
  end

  // Enabled count is floor(n * p / 1000): count the thousands reached.
  always_comb begin
    pprod = PPROD_W'(n) * PPROD_W'(s1_p_q);
    en    = '0;
    for (int m = 1; m <= CHANNELS; m++) begin
      if (pprod >= PPROD_W'(m * 1000)) en = en + CNT_W'(1);
    end
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (CNT_W'(i) < en) mask[slot[i]] = 1'b1;
    end
  end

  // ---------------- result register ----------------
  always_comb begin
    if (s2_free) begin
      out_valid_d = s1_valid_q;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      out_mask_q <= mask;
      out_cnt_q  <= COUNT_W'(en);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, out_cnt_q, out_mask_q};

endmodule
`default_nettype wire
